### sv/ssnf_pkg.sv
// Shared types, segment constants and digit table for the seven-segment formatter.
`timescale 1ns / 1ps

package ssnf_pkg;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_INT    = 2'd0,
    OP_TENTHS = 2'd1,
    OP_RAW    = 2'd2,
    OP_APPEND = 2'd3
  } op_e;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned PAT_W   = 32;
  localparam int unsigned MAG_W   = 14;   // magnitude of an in-range value (0..9999)

  // Bits within a digit byte: 0 upper right, 1 top, 2 middle, 3 upper left,
  // 4 lower left, 5 bottom, 6 lower right, 7 decimal point.
  localparam logic [7:0] SEG_MINUS = 8'h04;
  localparam logic [7:0] SEG_E     = 8'h3E;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_ZERO  = 8'h7B;

  localparam logic [PAT_W-1:0] SEG_ERROR = {4{SEG_E}};
  localparam logic [PAT_W-1:0] KEEP_HIGH = 32'hFFFF_FF00;

  localparam logic signed [VALUE_W-1:0] INT_HIGH = 32'sd9999;
  localparam logic signed [VALUE_W-1:0] INT_LOW  = -32'sd999;

  // Reciprocal constants: floor(m * R >> S) equals floor(m / D) for m <= 9999.
  localparam logic [16:0] RECIP10    = 17'd52429;  // shift 19
  localparam logic [12:0] RECIP100   = 13'd5243;   // shift 19
  localparam logic [13:0] RECIP1000  = 14'd8389;   // shift 23

  // One input beat.
  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [CHAR_W-1:0]         extra_char;
  } req_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = SEG_ZERO;
      4'd1:    s = 8'h41;
      4'd2:    s = 8'h37;
      4'd3:    s = 8'h67;
      4'd4:    s = 8'h4D;
      4'd5:    s = 8'h6E;
      4'd6:    s = 8'h7E;
      4'd7:    s = 8'h43;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### sv/seven_segment_number_formatter.sv
// Top level: formats one request beat into a four-digit seven-segment pattern.
`timescale 1ns / 1ps
//
// Usage
//   Input stream (s_*): tdata = {extra_char[7:0], value[31:0]}, tuser = operation.
//     operation 0 shows value as a left-justified integer (-999..9999),
//     1 shows value as signed tenths with a decimal point, 2 passes value
//     through as a raw pattern, 3 replaces the rightmost byte with extra_char.
//   Output stream (m_*): tdata = pattern (leftmost digit in bits 31:24),
//     tuser = out_of_range, set when an integer or tenths value is outside
//     -999..9999 and the E pattern is shown.
//   Path: a beat accepted into the input register moves on to the result
//     register and is then presented on m_tvalid_o.
//   Throughput: one beat per cycle while m_tready_i is high. The digit
//     split uses three independent constant-reciprocal multiplies in
//     parallel, so the whole format fits between the input and result registers.
//   Stall: when m_tready_i is low the result register holds; the input
//     register still takes a beat if it is empty, then s_tready_o drops until the
//     result is taken. No beat is lost or repeated.
//   Reset: rst_ni (async, active low) empties both registers; no output beat
//     appears until a new input beat is accepted.
//
module seven_segment_number_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [31:0] value, [39:32] extra_char
  input  logic [1:0]  s_tuser_i,   // [1:0] operation
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [31:0] pattern
  output logic        m_tuser_o    // [0] out_of_range
);
  import ssnf_pkg::*;

  // ---------------------------------------------------------------
  // Handshake: two-entry pipeline, each stage advances when the one
  // after it is empty or draining.
  // ---------------------------------------------------------------
  logic req_valid_q, req_valid_d;
  logic out_valid_q, out_valid_d;
  req_t req_q;
  logic out_adv, req_adv;

  assign out_adv    = !out_valid_q || m_tready_i;
  assign req_adv    = !req_valid_q || out_adv;
  assign s_tready_o = req_adv;

  assign req_valid_d = req_adv ? s_tvalid_i : req_valid_q;
  assign out_valid_d = out_adv ? req_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_adv && s_tvalid_i) begin
      req_q.op         <= op_e'(s_tuser_i);
      req_q.value      <= $signed(s_tdata_i[31:0]);
      req_q.extra_char <= s_tdata_i[39:32];
    end
  end

  // ---------------------------------------------------------------
  // Format logic
  // ---------------------------------------------------------------
  logic             neg, err;
  logic [MAG_W-1:0] mag;

  assign neg = req_q.value[VALUE_W-1];
  assign err = (req_q.value > INT_HIGH) || (req_q.value < INT_LOW);
  // only meaningful when in range
  assign mag = neg ? (MAG_W'(0) - req_q.value[MAG_W-1:0]) : req_q.value[MAG_W-1:0];

  // parallel constant divides by 10, 100, 1000
  logic [30:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;

  assign p10   = 31'(mag) * 31'(RECIP10);
  assign p100  = 27'(mag) * 27'(RECIP100);
  assign p1000 = 28'(mag) * 28'(RECIP1000);
  assign q10   = p10[28:19];
  assign q100  = p100[25:19];
  assign q1000 = p1000[26:23];

  logic [MAG_W-1:0] r0;
  logic [9:0]       r1;
  logic [6:0]       r2;
  logic [3:0]       d0, d1, d2, d3;

  assign r0 = mag - ((MAG_W'(q10) << 3) + (MAG_W'(q10) << 1));
  assign r1 = q10 - ((10'(q100) << 3) + (10'(q100) << 1));
  assign r2 = q100 - ((7'(q1000) << 3) + (7'(q1000) << 1));
  assign d0 = r0[3:0];
  assign d1 = r1[3:0];
  assign d2 = r2[3:0];
  assign d3 = q1000;

  logic [7:0] s0;
  logic [PAT_W-1:0] digits, pat_shift, pat_int;
  logic [1:0] lz;

  assign s0     = seg_digit(d0);
  assign digits = {seg_digit(d3), seg_digit(d2), seg_digit(d1), s0};

  // leading zeros dropped (at most three)
  always_comb begin
    if (d3 != 4'd0)      lz = 2'd0;
    else if (d2 != 4'd0) lz = 2'd1;
    else if (d1 != 4'd0) lz = 2'd2;
    else                 lz = 2'd3;
  end

  assign pat_shift = digits << {lz, 3'b000};

  always_comb begin
    if (err)      pat_int = SEG_ERROR;
    else if (neg) pat_int = {SEG_MINUS, pat_shift[31:8]};
    else          pat_int = pat_shift;
  end

  // tenths: leading zero below 1.0, decimal point position by magnitude
  logic       under_one, big100, big1000;
  logic [1:0] dp_pos;
  logic [PAT_W-1:0] pat_tenths, dp_mask;

  assign under_one = !err && (mag < MAG_W'(10));
  assign big100    = err || (mag >= MAG_W'(100));
  assign big1000   = err || (mag >= MAG_W'(1000));
  assign dp_pos    = {1'b0, neg} + {1'b0, big100} + {1'b0, big1000};
  assign dp_mask   = PAT_W'(SEG_DP) << {~dp_pos, 3'b000};

  always_comb begin
    if (under_one && neg)  pat_tenths = {SEG_MINUS, SEG_ZERO, s0, 8'h00};
    else if (under_one)    pat_tenths = {SEG_ZERO, s0, 16'h0000};
    else                   pat_tenths = pat_int;
  end

  logic [PAT_W-1:0] pattern_d, pattern_q;
  logic             oor_d, oor_q;

  always_comb begin
    case (req_q.op)
      OP_INT: begin
        pattern_d = pat_int;
        oor_d     = err;
      end
      OP_TENTHS: begin
        pattern_d = pat_tenths | dp_mask;
        oor_d     = err;
      end
      OP_RAW: begin
        pattern_d = req_q.value;
        oor_d     = 1'b0;
      end
      default: begin
        pattern_d = (req_q.value & KEEP_HIGH) | PAT_W'(req_q.extra_char);
        oor_d     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && req_valid_q) begin
      pattern_q <= pattern_d;
      oor_q     <= oor_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = pattern_q;
  assign m_tuser_o  = oor_q;

endmodule

### sv/ssnf_checker.sv
// Port-level checker for the seven-segment formatter, bound to the top level.
`timescale 1ns / 1ps

module ssnf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [31:0] m_tdata_o,
  input logic        m_tuser_o
);
  import ssnf_pkg::*;

  // output beat held while stalled
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("output beat dropped or changed under stall");

  // no output beat while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_tvalid_o)
    else $error("output valid during reset");

  // error beats carry E in every digit, with at most a decimal point added
  a_error_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |->
      m_tdata_o[30:24] == SEG_E[6:0] && m_tdata_o[22:16] == SEG_E[6:0] &&
      m_tdata_o[14:8] == SEG_E[6:0] && m_tdata_o[6:0] == SEG_E[6:0] &&
      $countones({m_tdata_o[31], m_tdata_o[23], m_tdata_o[15], m_tdata_o[7]}) <= 1)
    else $error("out_of_range beat without error pattern");

  // an output beat only follows an accepted input beat
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o && !(s_tvalid_i && s_tready_o) ##1
      !m_tvalid_o && !(s_tvalid_i && s_tready_o) |=> !m_tvalid_o)
    else $error("output beat without an input beat");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (.*);
